### rtl/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types and constants for the batch request parser: event kinds,
// error codes, configuration register indexes and the event beat layout.
// ----------------------------------------------------------------------------
package brp_pkg;

  // Largest operation count the parser will ever accept
  localparam int unsigned MAX_OPS = 256;
  localparam int unsigned OPS_W   = $clog2(MAX_OPS + 1);

  // Field widths fixed by the request format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned OPN_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    EV_TAG       = 4'd0,
    EV_BATCH_ID  = 4'd1,
    EV_OP_COUNT  = 4'd2,
    EV_OP_ID     = 4'd3,
    EV_OP_TYPE   = 4'd4,
    EV_FID       = 4'd5,
    EV_COUNT     = 4'd6,
    EV_NAME_CNT  = 4'd7,
    EV_NAME_LEN  = 4'd8,
    EV_NAME_BYTE = 4'd9,
    EV_OFFSET    = 4'd10,
    EV_DATA_BYTE = 4'd11,
    EV_DONE      = 4'd12,
    EV_ERROR     = 4'd13
  } ev_kind_e;

  // Error codes carried in the value of an error event
  localparam logic [VALUE_W-1:0] ERR_TYPE      = 64'd0;
  localparam logic [VALUE_W-1:0] ERR_TOO_MANY  = 64'd1;
  localparam logic [VALUE_W-1:0] ERR_TRUNCATED = 64'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQ_TYPE = 3'd0,
    CFG_WALK_OP  = 3'd1,
    CFG_READ_OP  = 3'd2,
    CFG_WRITE_OP = 3'd3,
    CFG_OP_LIMIT = 3'd4
  } cfg_idx_e;

  // One event beat
  typedef struct packed {
    ev_kind_e            kind;
    logic [VALUE_W-1:0]  value;
    logic [OPN_W-1:0]    opn;
    logic                final_run;
  } ev_t;

  // Events produced by one byte, pushed into the event queue together
  typedef struct packed {
    logic [1:0] cnt;
    ev_t        ev0;
    ev_t        ev1;
  } push_t;

endpackage

### rtl/brp_if.sv
// ----------------------------------------------------------------------------
// brp_if
// Valid/ready channels of the batch request parser: request bytes in,
// parse events out.
// ----------------------------------------------------------------------------
interface brp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface brp_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [63:0] event_value;
  logic [7:0]  op_number;
  logic        final_of_run;

  modport source (output valid, output event_kind, output event_value,
                  output op_number, output final_of_run, input ready);
  modport sink   (input valid, input event_kind, input event_value,
                  input op_number, input final_of_run, output ready);
endinterface

### rtl/brp_core.sv
// ----------------------------------------------------------------------------
// brp_core
// Input byte register, configuration registers and parse state. One
// registered byte is parsed per cycle whenever the event queue has room
// for two events.
// ----------------------------------------------------------------------------
module brp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [brp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [brp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // event queue
  input  logic                          q_space_i,
  output brp_pkg::push_t                push_o
);
  import brp_pkg::*;

  typedef enum logic [3:0] {
    PH_TYPE      = 4'd0,
    PH_TAG       = 4'd1,
    PH_BATCHID   = 4'd2,
    PH_OPCOUNT   = 4'd3,
    PH_OPID      = 4'd4,
    PH_OPTYPE    = 4'd5,
    PH_FID       = 4'd6,
    PH_COUNT     = 4'd7,
    PH_NAMECOUNT = 4'd8,
    PH_NAMELEN   = 4'd9,
    PH_NAMEBYTE  = 4'd10,
    PH_OFFSET    = 4'd11,
    PH_DATA      = 4'd12,
    PH_FINISHED  = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_WALK   = 2'd1,
    CLS_OFFSET = 2'd2
  } op_class_e;

  // Byte length of the field read in each phase
  function automatic logic [3:0] field_len(input phase_e ph);
    case (ph)
      PH_TAG:       field_len = 4'd2;
      PH_BATCHID:   field_len = 4'd4;
      PH_OPCOUNT:   field_len = 4'd4;
      PH_OPID:      field_len = 4'd4;
      PH_OPTYPE:    field_len = 4'd1;
      PH_FID:       field_len = 4'd4;
      PH_COUNT:     field_len = 4'd4;
      PH_NAMECOUNT: field_len = 4'd2;
      PH_NAMELEN:   field_len = 4'd2;
      PH_OFFSET:    field_len = 4'd8;
      default:      field_len = 4'd1;
    endcase
  endfunction

  // Configuration registers
  logic [7:0]            req_type_q, walk_op_q, read_op_q, write_op_q;
  logic [8:0]            op_limit_q;

  // Input register
  logic                  in_vq;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;

  // Parse state
  phase_e                phase_q, phase_d;
  logic [2:0]            fbc_q, fbc_d;
  logic [VALUE_W-1:0]    acc_q, acc_d;
  logic [OPS_W-1:0]      ops_q, ops_d;
  logic [OPN_W-1:0]      opos_q, opos_d;
  op_class_e             cls_q, cls_d;
  logic [31:0]           pay_q, pay_d;
  logic [15:0]           names_q, names_d;
  logic [15:0]           nbr_q, nbr_d;

  logic                  proc;
  push_t                 push;

  assign proc       = in_vq && q_space_i;
  assign in_ready_o = !in_vq || q_space_i;
  assign push_o     = push;

  // Configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_type_q <= 8'd0;
      walk_op_q  <= 8'd0;
      read_op_q  <= 8'd1;
      write_op_q <= 8'd2;
      op_limit_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REQ_TYPE: req_type_q <= cfg_data_i[7:0];
        CFG_WALK_OP:  walk_op_q  <= cfg_data_i[7:0];
        CFG_READ_OP:  read_op_q  <= cfg_data_i[7:0];
        CFG_WRITE_OP: write_op_q <= cfg_data_i[7:0];
        CFG_OP_LIMIT: op_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vq <= 1'b1;
    end else if (proc) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  // Parse step for the registered byte
  always_comb begin
    logic [3:0]         idx1;
    logic [VALUE_W-1:0] acc_new;
    logic [31:0]        v32;
    logic               do_next_name, do_start, do_end_op;
    logic               p_v, d_v, t_v;
    ev_t                p_ev, d_ev, t_ev;
    logic [1:0]         n;

    phase_d = phase_q;
    fbc_d   = fbc_q;
    acc_d   = acc_q;
    ops_d   = ops_q;
    opos_d  = opos_q;
    cls_d   = cls_q;
    pay_d   = pay_q;
    names_d = names_q;
    nbr_d   = nbr_q;

    idx1    = {1'b0, fbc_q} + 4'd1;
    acc_new = acc_q | ({56'd0, in_byte_q} << {fbc_q, 3'b000});
    v32     = acc_new[31:0];

    do_next_name = 1'b0;
    do_start     = 1'b0;
    do_end_op    = 1'b0;
    p_v  = 1'b0;
    d_v  = 1'b0;
    t_v  = 1'b0;
    p_ev = '{kind: EV_ERROR, value: '0, opn: opos_q, final_run: 1'b0};
    d_ev = '{kind: EV_DONE, value: '0, opn: '0, final_run: 1'b0};
    t_ev = '{kind: EV_ERROR, value: ERR_TRUNCATED, opn: '0, final_run: 1'b0};

    case (phase_q)
      PH_FINISHED: ;
      PH_TYPE: begin
        if (in_byte_q != req_type_q) begin
          p_v        = 1'b1;
          p_ev.value = ERR_TYPE;
          phase_d    = PH_FINISHED;
        end else begin
          fbc_d   = 3'd0;
          acc_d   = '0;
          phase_d = PH_TAG;
        end
      end
      PH_NAMEBYTE: begin
        p_v        = 1'b1;
        p_ev.kind  = EV_NAME_BYTE;
        p_ev.value = {56'd0, in_byte_q};
        nbr_d      = nbr_q - 16'd1;
        if (nbr_d == 16'd0) begin
          do_next_name = 1'b1;
        end
      end
      PH_DATA: begin
        p_v        = 1'b1;
        p_ev.kind  = EV_DATA_BYTE;
        p_ev.value = {56'd0, in_byte_q};
        pay_d      = pay_q - 32'd1;
        if (pay_d == 32'd0) begin
          do_end_op = 1'b1;
        end
      end
      PH_TAG, PH_BATCHID, PH_OPCOUNT, PH_OPID, PH_OPTYPE, PH_FID, PH_COUNT,
      PH_NAMECOUNT, PH_NAMELEN, PH_OFFSET: begin
        if (idx1 >= field_len(phase_q)) begin
          // field complete
          fbc_d      = 3'd0;
          acc_d      = '0;
          p_v        = 1'b1;
          p_ev.value = acc_new;
          case (phase_q)
            PH_TAG: begin
              p_ev.kind = EV_TAG;
              phase_d   = PH_BATCHID;
            end
            PH_BATCHID: begin
              p_ev.kind = EV_BATCH_ID;
              phase_d   = PH_OPCOUNT;
            end
            PH_OPCOUNT: begin
              if (v32 > 32'(op_limit_q) || v32 > 32'(MAX_OPS)) begin
                p_ev.value = ERR_TOO_MANY;
                phase_d    = PH_FINISHED;
              end else begin
                p_ev.kind = EV_OP_COUNT;
                ops_d     = v32[OPS_W-1:0];
                opos_d    = '0;
                if (v32 == 32'd0) begin
                  d_v     = 1'b1;
                  phase_d = PH_FINISHED;
                end else begin
                  phase_d = PH_OPID;
                end
              end
            end
            PH_OPID: begin
              p_ev.kind = EV_OP_ID;
              phase_d   = PH_OPTYPE;
            end
            PH_OPTYPE: begin
              p_ev.kind = EV_OP_TYPE;
              if (acc_new[7:0] == walk_op_q) begin
                cls_d = CLS_WALK;
              end else if (acc_new[7:0] == read_op_q || acc_new[7:0] == write_op_q) begin
                cls_d = CLS_OFFSET;
              end else begin
                cls_d = CLS_OTHER;
              end
              phase_d = PH_FID;
            end
            PH_FID: begin
              p_ev.kind = EV_FID;
              phase_d   = PH_COUNT;
            end
            PH_COUNT: begin
              p_ev.kind = EV_COUNT;
              pay_d     = v32;
              if (cls_q == CLS_WALK) begin
                phase_d = PH_NAMECOUNT;
              end else if (cls_q == CLS_OFFSET) begin
                phase_d = PH_OFFSET;
              end else begin
                do_start = 1'b1;
              end
            end
            PH_NAMECOUNT: begin
              p_ev.kind = EV_NAME_CNT;
              names_d   = acc_new[15:0];
              if (names_d == 16'd0) begin
                do_start = 1'b1;
              end else begin
                phase_d = PH_NAMELEN;
              end
            end
            PH_NAMELEN: begin
              p_ev.kind = EV_NAME_LEN;
              nbr_d     = acc_new[15:0];
              if (nbr_d == 16'd0) begin
                do_next_name = 1'b1;
              end else begin
                phase_d = PH_NAMEBYTE;
              end
            end
            default: begin
              p_ev.kind = EV_OFFSET;
              do_start  = 1'b1;
            end
          endcase
        end else begin
          fbc_d = idx1[2:0];
          acc_d = acc_new;
        end
      end
      default: phase_d = PH_FINISHED;
    endcase

    // End of one name
    if (do_next_name) begin
      names_d = names_q - 16'd1;
      if (names_d == 16'd0) begin
        do_start = 1'b1;
      end else begin
        phase_d = PH_NAMELEN;
      end
    end

    // Payload or end of operation
    if (do_start) begin
      if (pay_d != 32'd0) begin
        phase_d = PH_DATA;
      end else begin
        do_end_op = 1'b1;
      end
    end

    // End of operation
    if (do_end_op) begin
      ops_d  = ops_q - OPS_W'(1);
      opos_d = opos_q + OPN_W'(1);
      if (ops_d == '0) begin
        d_v     = 1'b1;
        phase_d = PH_FINISHED;
      end else begin
        phase_d = PH_OPID;
      end
    end

    // Buffer end: truncation check, then back to the type byte
    if (in_last_q) begin
      if (phase_d != PH_FINISHED) begin
        t_v      = 1'b1;
        t_ev.opn = opos_d;
      end
      phase_d = PH_TYPE;
      fbc_d   = 3'd0;
      acc_d   = '0;
      ops_d   = '0;
      opos_d  = '0;
      cls_d   = CLS_OTHER;
      pay_d   = 32'd0;
      names_d = 16'd0;
      nbr_d   = 16'd0;
    end

    // Pack up to two events in order
    n = 2'(p_v) + 2'(d_v) + 2'(t_v);
    if (n > 2'd2) begin
      n = 2'd2;
    end
    if (p_v) begin
      push.ev0 = p_ev;
      push.ev1 = d_v ? d_ev : t_ev;
    end else if (d_v) begin
      push.ev0 = d_ev;
      push.ev1 = t_ev;
    end else begin
      push.ev0 = t_ev;
      push.ev1 = t_ev;
    end
    push.ev0.final_run = (n == 2'd1);
    push.ev1.final_run = 1'b1;
    push.cnt = proc ? n : 2'd0;
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      fbc_q   <= 3'd0;
      acc_q   <= '0;
      ops_q   <= '0;
      opos_q  <= '0;
      cls_q   <= CLS_OTHER;
      pay_q   <= 32'd0;
      names_q <= 16'd0;
      nbr_q   <= 16'd0;
    end else if (proc) begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      acc_q   <= acc_d;
      ops_q   <= ops_d;
      opos_q  <= opos_d;
      cls_q   <= cls_d;
      pay_q   <= pay_d;
      names_q <= names_d;
      nbr_q   <= nbr_d;
    end
  end

endmodule

### rtl/brp_evq.sv
// ----------------------------------------------------------------------------
// brp_evq
// Four-entry event queue: takes up to two events per cycle from the parse
// step and hands out one event beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module brp_evq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  brp_pkg::push_t push_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output brp_pkg::ev_t   out_ev_o
);
  import brp_pkg::*;

  ev_t        mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_ev_o    = mem_q[rp_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two events from one byte
  assign space_o     = (cnt_q <= 3'd2);

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.ev0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + 2'd1] <= push_i.ev1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_q + push_i.cnt;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_i.cnt) - 3'(pop);
    end
  end

endmodule

### rtl/batch_request_parser.sv
// ----------------------------------------------------------------------------
// batch_request_parser
// Byte-serial parser of little-endian batch requests that turns each field,
// name byte and payload byte into an event beat.
// ----------------------------------------------------------------------------
//  channel  dir  beat                                         handshake
//  req_i    in   byte_in[7:0], last_byte                      valid/ready
//  evt_o    out  event_kind[3:0], event_value[63:0],
//                op_number[7:0], final_of_run                 valid/ready
//  cfg      in   cfg_we_i, cfg_idx_i[2:0], cfg_data_i[8:0]    write strobe
//
// One request byte is parsed per cycle while the event queue has room; a byte
// is held in the input register before its events enter that four-entry queue.
// A byte that yields two events (an event followed by done or truncation)
// adds more to the queue than one output beat takes out, so bytes stall
// while such bytes follow each other; the queue drain rate sets the pace.
// Reset clears the parse state and the queue at once; no clearing pass.
// Bytes stall only when the queue cannot take two more events.
// ----------------------------------------------------------------------------
module batch_request_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  brp_byte_if.sink                       req_i,
  brp_event_if.source                    evt_o,
  input  logic                           cfg_we_i,
  input  logic [brp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import brp_pkg::*;

  push_t push;
  logic  space;
  ev_t   ev;

  // Parse step
  brp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .in_byte_i  (req_i.byte_in),
    .in_last_i  (req_i.last_byte),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_space_i  (space),
    .push_o     (push)
  );

  // Event queue
  brp_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (evt_o.valid),
    .out_ready_i (evt_o.ready),
    .out_ev_o    (ev)
  );

  assign evt_o.event_kind   = ev.kind;
  assign evt_o.event_value  = ev.value;
  assign evt_o.op_number    = ev.opn;
  assign evt_o.final_of_run = ev.final_run;

endmodule

### tb/brp_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brp_event_checker
// Watches the byte and event channels of the batch request parser, keeps a
// shadow of its parse state and registers, works out the events each
// accepted byte must cause and compares every accepted event beat with them.
// ----------------------------------------------------------------------------
module brp_event_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  logic [brp_pkg::BYTE_W-1:0]     req_byte_i,
  input  logic                           req_last_i,
  input  logic                           evt_valid_i,
  input  logic                           evt_ready_i,
  input  logic [brp_pkg::KIND_W-1:0]     evt_kind_i,
  input  logic [brp_pkg::VALUE_W-1:0]    evt_value_i,
  input  logic [brp_pkg::OPN_W-1:0]      evt_opn_i,
  input  logic                           evt_final_i,
  input  logic                           cfg_we_i,
  input  logic [brp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import brp_pkg::*;

  typedef enum logic [3:0] {
    PH_TYPE, PH_TAG, PH_BATCH_ID, PH_OP_COUNT, PH_OP_ID, PH_OP_TYPE, PH_FID,
    PH_COUNT, PH_NAME_CNT, PH_NAME_LEN, PH_NAME_BYTE, PH_OFFSET, PH_DATA,
    PH_FINISHED
  } phase_e;

  typedef enum logic [1:0] {CLS_OTHER, CLS_WALK, CLS_OFFSET} op_class_e;

  // Shadow registers
  logic [7:0] exp_req_type;
  logic [7:0] exp_walk_op;
  logic [7:0] exp_read_op;
  logic [7:0] exp_write_op;
  logic [8:0] exp_op_limit;

  // Shadow parse state
  phase_e       phase;
  logic [2:0]   field_pos;
  logic [63:0]  field_acc;
  logic [31:0]  ops_left;
  logic [7:0]   op_index;
  op_class_e    op_kind;
  logic [31:0]  data_left;
  logic [15:0]  names_left;
  logic [15:0]  name_left;

  ev_t expected_events[$];
  ev_t byte_events[$];
  int  fails;

  // Bytes per field of each phase
  function automatic int field_width(phase_e ph);
    case (ph)
      PH_TAG, PH_NAME_CNT, PH_NAME_LEN:                 return 2;
      PH_BATCH_ID, PH_OP_COUNT, PH_OP_ID, PH_FID,
      PH_COUNT:                                         return 4;
      PH_OFFSET:                                        return 8;
      default:                                          return 1;
    endcase
  endfunction

  task automatic clear_parse_state();
    phase      = PH_TYPE;
    field_pos  = '0;
    field_acc  = '0;
    ops_left   = '0;
    op_index   = '0;
    op_kind    = CLS_OTHER;
    data_left  = '0;
    names_left = '0;
    name_left  = '0;
  endtask

  // At most two events come out of one byte
  task automatic push_event(ev_kind_e k, logic [63:0] v, logic [7:0] o);
    if (byte_events.size() < 2)
      byte_events.push_back('{kind: k, value: v, opn: o, final_run: 1'b0});
  endtask

  task automatic flag_error(logic [63:0] code);
    push_event(EV_ERROR, code, op_index);
    phase = PH_FINISHED;
  endtask

  task automatic close_op();
    ops_left = ops_left - 1;
    op_index = op_index + 8'd1;
    if (ops_left == 0) begin
      push_event(EV_DONE, '0, '0);
      phase = PH_FINISHED;
    end else begin
      phase = PH_OP_ID;
    end
  endtask

  task automatic begin_payload();
    if (data_left > 0) phase = PH_DATA;
    else close_op();
  endtask

  task automatic advance_name();
    names_left = names_left - 1;
    if (names_left == 0) begin_payload();
    else phase = PH_NAME_LEN;
  endtask

  // A field has been gathered
  task automatic finish_field(logic [63:0] v);
    case (phase)
      PH_TAG: begin
        push_event(EV_TAG, v, op_index);
        phase = PH_BATCH_ID;
      end
      PH_BATCH_ID: begin
        push_event(EV_BATCH_ID, v, op_index);
        phase = PH_OP_COUNT;
      end
      PH_OP_COUNT: begin
        if (v > exp_op_limit || v > MAX_OPS) begin
          flag_error(ERR_TOO_MANY);
        end else begin
          push_event(EV_OP_COUNT, v, op_index);
          ops_left = v[31:0];
          op_index = '0;
          if (v == 0) begin
            push_event(EV_DONE, '0, '0);
            phase = PH_FINISHED;
          end else begin
            phase = PH_OP_ID;
          end
        end
      end
      PH_OP_ID: begin
        push_event(EV_OP_ID, v, op_index);
        phase = PH_OP_TYPE;
      end
      PH_OP_TYPE: begin
        push_event(EV_OP_TYPE, v, op_index);
        // walk wins when opcodes overlap
        if (v == exp_walk_op) op_kind = CLS_WALK;
        else if (v == exp_read_op || v == exp_write_op) op_kind = CLS_OFFSET;
        else op_kind = CLS_OTHER;
        phase = PH_FID;
      end
      PH_FID: begin
        push_event(EV_FID, v, op_index);
        phase = PH_COUNT;
      end
      PH_COUNT: begin
        push_event(EV_COUNT, v, op_index);
        data_left = v[31:0];
        if (op_kind == CLS_WALK) phase = PH_NAME_CNT;
        else if (op_kind == CLS_OFFSET) phase = PH_OFFSET;
        else begin_payload();
      end
      PH_NAME_CNT: begin
        push_event(EV_NAME_CNT, v, op_index);
        names_left = v[15:0];
        if (names_left == 0) begin_payload();
        else phase = PH_NAME_LEN;
      end
      PH_NAME_LEN: begin
        push_event(EV_NAME_LEN, v, op_index);
        name_left = v[15:0];
        if (name_left == 0) advance_name();
        else phase = PH_NAME_BYTE;
      end
      PH_OFFSET: begin
        push_event(EV_OFFSET, v, op_index);
        begin_payload();
      end
      default: ;
    endcase
  endtask

  // Predict the events caused by one accepted byte
  task automatic parse_byte(logic [7:0] b, logic last);
    logic [63:0] v;
    byte_events.delete();
    case (phase)
      PH_FINISHED: ;
      PH_TYPE: begin
        if (b != exp_req_type) begin
          flag_error(ERR_TYPE);
        end else begin
          field_pos = '0;
          field_acc = '0;
          phase     = PH_TAG;
        end
      end
      PH_NAME_BYTE: begin
        push_event(EV_NAME_BYTE, 64'(b), op_index);
        name_left = name_left - 1;
        if (name_left == 0) advance_name();
      end
      PH_DATA: begin
        push_event(EV_DATA_BYTE, 64'(b), op_index);
        data_left = data_left - 1;
        if (data_left == 0) close_op();
      end
      default: begin
        // little-endian gather
        field_acc = field_acc | (64'(b) << (8 * field_pos));
        if (int'(field_pos) + 1 >= field_width(phase)) begin
          v         = field_acc;
          field_pos = '0;
          field_acc = '0;
          finish_field(v);
        end else begin
          field_pos = field_pos + 3'd1;
        end
      end
    endcase
    // buffer end: flag an unfinished request, then start over
    if (last) begin
      if (phase != PH_FINISHED) push_event(EV_ERROR, ERR_TRUNCATED, op_index);
      clear_parse_state();
    end
    if (byte_events.size() > 0) byte_events[byte_events.size()-1].final_run = 1'b1;
    foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
  endtask

  task automatic check_event();
    ev_t exp;
    if (expected_events.size() == 0) begin
      $error("unexpected event beat: kind %0d value %0h op %0d",
             evt_kind_i, evt_value_i, evt_opn_i);
      fails++;
    end else begin
      exp = expected_events.pop_front();
      if (evt_kind_i != exp.kind) begin
        $error("event_kind: expected %0d, actual %0d", exp.kind, evt_kind_i);
        fails++;
      end
      if (evt_value_i != exp.value) begin
        $error("event_value: expected %0h, actual %0h", exp.value, evt_value_i);
        fails++;
      end
      if (evt_opn_i != exp.opn) begin
        $error("op_number: expected %0d, actual %0d", exp.opn, evt_opn_i);
        fails++;
      end
      if (evt_final_i != exp.final_run) begin
        $error("final_of_run: expected %0b, actual %0b", exp.final_run, evt_final_i);
        fails++;
      end
    end
  endtask

  // Outputs are checked before the byte of the same edge is parsed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_req_type = 8'd0;
      exp_walk_op  = 8'd0;
      exp_read_op  = 8'd1;
      exp_write_op = 8'd2;
      exp_op_limit = 9'd256;
      clear_parse_state();
      expected_events.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (evt_valid_i && evt_ready_i) check_event();
      if (req_valid_i && req_ready_i) parse_byte(req_byte_i, req_last_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REQ_TYPE: exp_req_type = cfg_data_i[7:0];
          CFG_WALK_OP:  exp_walk_op  = cfg_data_i[7:0];
          CFG_READ_OP:  exp_read_op  = cfg_data_i[7:0];
          CFG_WRITE_OP: exp_write_op = cfg_data_i[7:0];
          CFG_OP_LIMIT: exp_op_limit = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= expected_events.size();
    end
  end

endmodule

### tb/tb_batch_request_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_batch_request_parser
// Drives batch requests into the parser under several register settings:
// a few directed buffers for the header corner cases, then random requests,
// mostly well formed with random content, the rest truncated, mistyped,
// oversized or plain noise. The checker beside the block predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_batch_request_parser;
  import brp_pkg::*;

  localparam int PHASE_BYTES  = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  brp_byte_if  req_if ();
  brp_event_if evt_if ();

  batch_request_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .evt_o      (evt_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  brp_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_byte_i   (req_if.byte_in),
    .req_last_i   (req_if.last_byte),
    .evt_valid_i  (evt_if.valid),
    .evt_ready_i  (evt_if.ready),
    .evt_kind_i   (evt_if.event_kind),
    .evt_value_i  (evt_if.event_value),
    .evt_opn_i    (evt_if.op_number),
    .evt_final_i  (evt_if.final_of_run),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // Current register values, used to shape the requests
  logic [7:0] req_type_q;
  logic [7:0] walk_op_q;
  logic [7:0] read_op_q;
  logic [7:0] write_op_q;
  logic [8:0] op_limit_q;

  logic [7:0] req_bytes[$];
  int         burst_left;
  int         phase_bytes;
  int         hold_reqs;

  // Write all five registers on consecutive edges
  task automatic write_settings(logic [7:0] rt, logic [7:0] wk, logic [7:0] rd,
                                logic [7:0] wr, logic [8:0] lim);
    req_type_q = rt;
    walk_op_q  = wk;
    read_op_q  = rd;
    write_op_q = wr;
    op_limit_q = lim;
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_REQ_TYPE;
    cfg_data <= {1'b0, rt};
    @(posedge clk_i);
    cfg_idx  <= CFG_WALK_OP;
    cfg_data <= {1'b0, wk};
    @(posedge clk_i);
    cfg_idx  <= CFG_READ_OP;
    cfg_data <= {1'b0, rd};
    @(posedge clk_i);
    cfg_idx  <= CFG_WRITE_OP;
    cfg_data <= {1'b0, wr};
    @(posedge clk_i);
    cfg_idx  <= CFG_OP_LIMIT;
    cfg_data <= lim;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Let every expected event drain, then let the pipe settle; the first
  // edge lets the count pick up the events of the last accepted byte
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One byte beat; the sender works in bursts separated by gaps
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.byte_in   <= b;
    req_if.last_byte <= last;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Send the first n bytes of the buffer, the last one marked
  task automatic send_bytes(int n);
    for (int i = 0; i < n; i++) begin
      send_byte(req_bytes[i], i == n - 1);
      phase_bytes++;
    end
  endtask

  task automatic push_field(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) req_bytes.push_back(v[8*i +: 8]);
  endtask

  // Build a request; wild lets lengths take any value, the parts that
  // follow are then cut short and the buffer ends up truncated
  task automatic build_request(bit wild);
    int          n_ops;
    int          max_ops;
    logic [7:0]  op;
    logic [31:0] count;
    logic [15:0] names;
    logic [15:0] nlen;
    req_bytes.delete();
    req_bytes.push_back(req_type_q);
    push_field(64'($urandom), 2);
    push_field(64'($urandom), 4);
    max_ops = (op_limit_q < 4) ? int'(op_limit_q) : 4;
    n_ops = $urandom_range(0, max_ops);
    push_field(64'(n_ops), 4);
    for (int i = 0; i < n_ops; i++) begin
      push_field(64'($urandom), 4);
      case ($urandom_range(0, 3))
        0:       op = walk_op_q;
        1:       op = read_op_q;
        2:       op = write_op_q;
        default: op = 8'($urandom);
      endcase
      push_field(64'(op), 1);
      push_field(64'($urandom), 4);
      count = (wild && $urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 5);
      push_field(64'(count), 4);
      if (op == walk_op_q) begin
        names = (wild && $urandom_range(0, 2) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 3));
        push_field(64'(names), 2);
        for (int j = 0; j < ((names > 3) ? 3 : int'(names)); j++) begin
          nlen = (wild && $urandom_range(0, 2) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 4));
          push_field(64'(nlen), 2);
          for (int k = 0; k < ((nlen > 4) ? 4 : int'(nlen)); k++)
            req_bytes.push_back(8'($urandom));
        end
      end else if (op == read_op_q || op == write_op_q) begin
        push_field({$urandom, $urandom}, 8);
      end
      for (int k = 0; k < ((count > 6) ? 6 : int'(count)); k++)
        req_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic send_random_request();
    int          r;
    logic [31:0] n_bad;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      // well formed, sometimes with ignored bytes after done
      build_request(1'b0);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom));
      send_bytes(req_bytes.size());
    end else if (r < 80) begin
      // cut short anywhere
      build_request(1'b1);
      send_bytes($urandom_range(1, req_bytes.size()));
    end else if (r < 87) begin
      // wrong type byte
      req_bytes.delete();
      req_bytes.push_back(req_type_q ^ 8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 4)) req_bytes.push_back(8'($urandom));
      send_bytes(req_bytes.size());
    end else if (r < 93) begin
      // operation count over the limit
      req_bytes.delete();
      req_bytes.push_back(req_type_q);
      push_field(64'($urandom), 6);
      n_bad = $urandom;
      if ($urandom_range(0, 1) == 0 || n_bad <= op_limit_q) n_bad = op_limit_q + 1;
      push_field(64'(n_bad), 4);
      repeat ($urandom_range(0, 5)) req_bytes.push_back(8'($urandom));
      send_bytes(req_bytes.size());
    end else begin
      // noise, sometimes starting with a valid type byte
      req_bytes.delete();
      repeat ($urandom_range(1, 16)) req_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 0) req_bytes[0] = req_type_q;
      send_bytes(req_bytes.size());
    end
  endtask

  task automatic apply_phase_settings(int p);
    logic [7:0] shared_op;
    shared_op = 8'($urandom);
    case (p)
      0: write_settings(8'h00, 8'h00, 8'h01, 8'h02, 9'd256);
      1: write_settings(8'hFF, 8'hFF, 8'h00, 8'h80, 9'd0);
      2: write_settings(8'h5A, 8'h03, 8'h03, 8'h04, 9'd1);
      3: write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        9'($urandom_range(0, 256)));
      4: write_settings(8'($urandom), shared_op, shared_op, shared_op, 9'd256);
      default: write_settings(8'($urandom), 8'($urandom_range(0, 3)),
                              8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                              9'($urandom_range(2, 256)));
    endcase
  endtask

  // Receiver: ready pattern changes mode now and then; a long hold-off on demand
  initial begin
    int mode;
    int mode_left;
    int hold;
    int hold_seen;
    int cyc;
    mode      = 0;
    mode_left = 0;
    hold      = 0;
    hold_seen = 0;
    cyc       = 0;
    evt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold      = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      cyc++;
      if (hold > 0) begin
        hold--;
        evt_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       evt_if.ready <= 1'b1;
          1:       evt_if.ready <= 1'($urandom_range(0, 1));
          2:       evt_if.ready <= ($urandom_range(0, 3) == 0);
          default: evt_if.ready <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    hold_reqs  = 0;
    burst_left = 0;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.byte_in   <= '0;
    req_if.last_byte <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_REQ_TYPE;
    cfg_data         <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_phase_settings(0);

    // wrong type byte, then a lone type byte cut off by the buffer end
    req_bytes = '{8'hFF};
    send_bytes(1);
    req_bytes = '{8'h00};
    send_bytes(1);
    // zero operations with all-ones header fields
    req_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(req_bytes.size());
    // one operation over the limit
    req_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h01, 8'h00, 8'h00};
    send_bytes(req_bytes.size());

    // random phases, one register setting each
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_idle();
        apply_phase_settings(p);
      end
      if (p == 0 || p == 4) hold_reqs++;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_request();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/brp_pkg.sv
rtl/brp_if.sv
rtl/brp_core.sv
rtl/brp_evq.sv
rtl/batch_request_parser.sv
tb/brp_event_checker.sv
tb/tb_batch_request_parser.sv
